### design/sfc_pkg.sv
package sfc_pkg;

    // Q16.32 word widths
    localparam int SW = 48;
    localparam int UW = 47;

    localparam logic [UW-1:0] MAX_U  = {UW{1'b1}};
    localparam logic [UW-1:0] Q_ONE  = 47'h0_0001_0000_0000;
    localparam logic [SW-1:0] NEG_LIM = 48'h8000_0000_0000;

    // one quotient bit per divider stage, plus the entry stage
    localparam int DIV_STEPS = 47;

    localparam int QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_R2  = 3'd0;
    localparam logic [2:0] REG_MAX_R2  = 3'd1;
    localparam logic [2:0] REG_SCALE   = 3'd2;
    localparam logic [2:0] REG_LIMIT_X = 3'd3;
    localparam logic [2:0] REG_LIMIT_Y = 3'd4;
    localparam logic [2:0] REG_LIMIT_Z = 3'd5;
    localparam logic [2:0] REG_MODE    = 3'd6;
    localparam logic [2:0] REG_WINDOW  = 3'd7;

    // fold kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_INNER = 2'd1;
    localparam logic [1:0] KIND_OUTER = 2'd2;

    typedef struct packed {
        logic [UW-1:0] min_r2;
        logic [UW-1:0] max_r2;
        logic [SW-1:0] scale;
        logic [UW-1:0] limit_x;
        logic [UW-1:0] limit_y;
        logic [UW-1:0] limit_z;
        logic [1:0]    mode_flags;
        logic [31:0]   iter_window;
    } cfg_t;

    // item as it travels from the front through the back
    typedef struct packed {
        logic [3:0]         neg;
        logic [3:0][SW-1:0] mag;
        logic [UW-1:0]      de;
        logic               win;
        logic               cub;
        logic [1:0]         kind;
        logic [UW-1:0]      rr;
        logic [UW-1:0]      aux;
    } side_t;

endpackage

### design/sfc_mulq.sv
module sfc_mulq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_i,
    input  sfc_pkg::side_t      tag_i,
    input  logic [47:0]         a,
    input  logic [47:0]         b,
    input  logic [47:0]         cap,
    output logic                vld_o,
    output sfc_pkg::side_t      tag_o,
    output logic [47:0]         p
);
    import sfc_pkg::*;

    logic          v1_reg, v2_reg;
    side_t         tag1_reg, tag2_reg;
    logic [47:0]   pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [47:0]   cap1_reg, p_reg;
    logic [95:0]   full;
    logic [63:0]   hi;
    logic [47:0]   p_next;

    // hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld_i;
            v2_reg <= v1_reg;
        end
    end

    // form 24 by 24 partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag1_reg <= tag_i;
            cap1_reg <= cap;
            pp00_reg <= a[23:0]  * b[23:0];
            pp01_reg <= a[23:0]  * b[47:24];
            pp10_reg <= a[47:24] * b[23:0];
            pp11_reg <= a[47:24] * b[47:24];
        end
    end

    // sum, drop fraction bits, cap
    always_comb
    begin
        full = {pp11_reg, 48'd0} + {24'd0, pp01_reg, 24'd0}
             + {24'd0, pp10_reg, 24'd0} + {48'd0, pp00_reg};
        hi = full[95:32];
        p_next = (hi > {16'd0, cap1_reg}) ? cap1_reg : hi[47:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag2_reg <= tag1_reg;
            p_reg <= p_next;
        end
    end

    assign vld_o = v2_reg;
    assign tag_o = tag2_reg;
    assign p = p_reg;

endmodule

### design/sfc_divq.sv
module sfc_divq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_i,
    input  sfc_pkg::side_t  tag_i,
    input  logic [46:0]     a,
    input  logic [47:0]     b,
    output logic            vld_o,
    output sfc_pkg::side_t  tag_o,
    output logic [46:0]     q
);
    import sfc_pkg::*;

    logic          v_reg   [0:DIV_STEPS];
    side_t         tag_reg [0:DIV_STEPS];
    logic          sat_reg [0:DIV_STEPS];
    logic [47:0]   r_reg   [0:DIV_STEPS];
    logic [47:0]   d_reg   [0:DIV_STEPS];
    logic [46:0]   nb_reg  [0:DIV_STEPS];
    logic [46:0]   q_reg   [0:DIV_STEPS];

    // entry: detect zero divisor or overflow, load partial remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= vld_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tag_i;
            sat_reg[0] <= (b == 48'd0) || ({16'd0, a} >= {b, 15'd0});
            r_reg[0]   <= {16'd0, a[46:15]};
            d_reg[0]   <= b;
            nb_reg[0]  <= {a[14:0], 32'd0};
            q_reg[0]   <= '0;
        end
    end

    // one restoring step per stage
    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_step
        logic [48:0] trial;
        logic [48:0] diff;
        logic        take;

        assign trial = {r_reg[i-1], nb_reg[i-1][46]};
        assign diff  = trial - {1'b0, d_reg[i-1]};
        assign take  = (trial >= {1'b0, d_reg[i-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[i] <= tag_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
                d_reg[i]   <= d_reg[i-1];
                r_reg[i]   <= take ? diff[47:0] : trial[47:0];
                nb_reg[i]  <= {nb_reg[i-1][45:0], 1'b0};
                q_reg[i]   <= {q_reg[i-1][45:0], take};
            end
        end
    end

    assign vld_o = v_reg[DIV_STEPS];
    assign tag_o = tag_reg[DIV_STEPS];
    assign q = sat_reg[DIV_STEPS] ? MAX_U : q_reg[DIV_STEPS];

endmodule

### design/sfc_queue.sv
module sfc_queue #(
    parameter int DEPTH = sfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sfc_pkg::side_t  push_data,
    output logic            full,
    input  logic            pop,
    output sfc_pkg::side_t  head,
    output logic            empty
);
    import sfc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    side_t          mem [0:DEPTH-1];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/sfc_front.sv
module sfc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         iter_window,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [47:0]  coord_x,
    input  logic signed [47:0]  coord_y,
    input  logic signed [47:0]  coord_z,
    input  logic signed [47:0]  coord_w,
    input  logic [15:0]         iteration,
    input  logic [46:0]         de_in,
    output logic                push,
    output sfc_pkg::side_t      push_data,
    input  logic                full
);
    import sfc_pkg::*;

    logic               v_reg, v_next;
    side_t              item_reg, item_next;
    logic [3:0][SW-1:0] c;
    logic               accept;

    assign in_stall = v_reg && full;
    assign accept   = in_valid && !in_stall;
    assign push     = v_reg && !full;
    assign push_data = item_reg;

    // take magnitudes, signs and window membership
    always_comb
    begin
        c = {$unsigned(coord_w), $unsigned(coord_z), $unsigned(coord_y), $unsigned(coord_x)};
        item_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            item_next.neg[k] = c[k][SW-1];
            item_next.mag[k] = c[k][SW-1] ? (48'd0 - c[k]) : c[k];
        end
        item_next.de  = de_in;
        item_next.win = (iteration >= iter_window[15:0]) && (iteration < iter_window[31:16]);
    end

    always_comb
    begin
        v_next = v_reg;
        if (accept)
        begin
            v_next = 1'b1;
        end
        else if (push)
        begin
            v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### design/sfc_back.sv
module sfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sfc_pkg::cfg_t       cfg,
    input  sfc_pkg::side_t      head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [47:0]  out_x,
    output logic signed [47:0]  out_y,
    output logic signed [47:0]  out_z,
    output logic signed [47:0]  out_w,
    output logic [46:0]         de_out,
    output logic [1:0]          fold_kind
);
    import sfc_pkg::*;

    logic               adv;
    logic               sneg;
    logic [SW-1:0]      smag;

    logic               vA, vC, vE, vG, vI, vK;
    side_t              tagA, tagC, tagE, tagG, tagI, tagK;
    logic [3:0][SW-1:0] sqA;
    logic [2:0][UW-1:0] qC;
    logic [SW-1:0]      r2E, gI;
    logic [UW-1:0]      ratioG;
    logic [4:0][SW-1:0] pK;
    logic [2:0][UW-1:0] lim;

    logic               vB_reg, vD_reg, vF_reg, vH_reg, out_v_reg;
    side_t              sB_reg, sB_next, sD_reg, sD_next, sF_reg, sH_reg, sH_next;
    logic [2:0][UW-1:0] tvB_reg, tvB_next;
    logic [UW-1:0]      dvF_reg, dvF_next;
    logic [3:0][SW-1:0] out_reg, out_next;
    logic [UW-1:0]      de_reg, de_next;
    logic [1:0]         kind_reg;

    logic [48:0]        sum_rr;
    logic [UW-1:0]      rr_b, low, r2, r2c;
    logic [SW-1:0]      de_sum;
    logic               n;

    assign adv  = !(out_v_reg && out_stall);
    assign pop  = adv && !empty;
    assign sneg = cfg.scale[SW-1];
    assign smag = sneg ? (48'd0 - cfg.scale) : cfg.scale;
    assign lim  = {cfg.limit_z, cfg.limit_y, cfg.limit_x};

    // square each component
    for (genvar k = 0; k < 4; k++)
    begin : g_sq
        if (k == 0)
        begin : g_tag
            sfc_mulq u_mul (
                .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(!empty), .tag_i(head),
                .a(head.mag[k]), .b(head.mag[k]), .cap({1'b0, MAX_U}),
                .vld_o(vA), .tag_o(tagA), .p(sqA[k])
            );
        end
        else
        begin : g_lane
            sfc_mulq u_mul (
                .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(1'b0), .tag_i('0),
                .a(head.mag[k]), .b(head.mag[k]), .cap({1'b0, MAX_U}),
                .vld_o(), .tag_o(), .p(sqA[k])
            );
        end
    end

    // sum radius, run cuboid test, classify fold
    always_comb
    begin
        sum_rr = {2'b0, sqA[0][UW-1:0]} + {2'b0, sqA[1][UW-1:0]}
               + {2'b0, sqA[2][UW-1:0]} + {2'b0, sqA[3][UW-1:0]};
        rr_b = (sum_rr > {2'b0, MAX_U}) ? MAX_U : sum_rr[UW-1:0];
        for (int k = 0; k < 3; k++)
        begin
            if (cfg.mode_flags[0])
            begin
                tvB_next[k] = sqA[k][UW-1:0];
            end
            else
            begin
                tvB_next[k] = tagA.mag[k][SW-1] ? MAX_U : tagA.mag[k][UW-1:0];
            end
        end
        sB_next = tagA;
        sB_next.rr = rr_b;
        sB_next.cub = tagA.win && (tvB_next[0] < cfg.limit_x)
                    && (tvB_next[1] < cfg.limit_y) && (tvB_next[2] < cfg.limit_z);
        if (sB_next.cub)
        begin
            sB_next.kind = KIND_INNER;
        end
        else if (!tagA.win && (rr_b < cfg.min_r2))
        begin
            sB_next.kind = KIND_INNER;
        end
        else if (rr_b < cfg.max_r2)
        begin
            sB_next.kind = KIND_OUTER;
        end
        else
        begin
            sB_next.kind = KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vB_reg <= 1'b0;
            vD_reg <= 1'b0;
            vF_reg <= 1'b0;
            vH_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            vB_reg <= vA;
            vD_reg <= vC;
            vF_reg <= vE;
            vH_reg <= vG;
            out_v_reg <= vK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sB_reg  <= sB_next;
            tvB_reg <= tvB_next;
        end
    end

    // divide each limit by its test value
    for (genvar k = 0; k < 3; k++)
    begin : g_lim
        if (k == 0)
        begin : g_tag
            sfc_divq u_div (
                .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(vB_reg), .tag_i(sB_reg),
                .a(lim[k]), .b({1'b0, tvB_reg[k]}),
                .vld_o(vC), .tag_o(tagC), .q(qC[k])
            );
        end
        else
        begin : g_lane
            sfc_divq u_div (
                .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(1'b0), .tag_i('0),
                .a(lim[k]), .b({1'b0, tvB_reg[k]}),
                .vld_o(), .tag_o(), .q(qC[k])
            );
        end
    end

    // pick the smallest ratio
    always_comb
    begin
        low = qC[0];
        if (qC[1] < low)
        begin
            low = qC[1];
        end
        if (qC[2] < low)
        begin
            low = qC[2];
        end
        sD_next = tagC;
        sD_next.aux = low;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sD_reg <= sD_next;
        end
    end

    sfc_mulq u_mul_r2 (
        .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(vD_reg), .tag_i(sD_reg),
        .a({1'b0, sD_reg.rr}), .b({1'b0, sD_reg.aux}), .cap({1'b0, MAX_U}),
        .vld_o(vE), .tag_o(tagE), .p(r2E)
    );

    // choose the squared radius to divide by
    always_comb
    begin
        r2  = r2E[UW-1:0];
        r2c = (cfg.mode_flags[1] && (r2 > cfg.max_r2)) ? cfg.max_r2 : r2;
        if (tagE.cub)
        begin
            dvF_next = r2c;
        end
        else if (tagE.kind == KIND_INNER)
        begin
            dvF_next = cfg.min_r2;
        end
        else
        begin
            dvF_next = tagE.rr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sF_reg  <= tagE;
            dvF_reg <= dvF_next;
        end
    end

    sfc_divq u_div_ratio (
        .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(vF_reg), .tag_i(sF_reg),
        .a(cfg.max_r2), .b({1'b0, dvF_reg}),
        .vld_o(vG), .tag_o(tagG), .q(ratioG)
    );

    // drop the ratio to one where no fold applies
    always_comb
    begin
        sH_next = tagG;
        sH_next.aux = (tagG.kind == KIND_NONE) ? Q_ONE : ratioG;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sH_reg <= sH_next;
        end
    end

    sfc_mulq u_mul_gain (
        .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(vH_reg), .tag_i(sH_reg),
        .a(smag), .b({1'b0, sH_reg.aux}), .cap({1'b0, MAX_U}),
        .vld_o(vI), .tag_o(tagI), .p(gI)
    );

    // scale point components and derivative
    for (genvar k = 0; k < 4; k++)
    begin : g_out
        if (k == 0)
        begin : g_tag
            sfc_mulq u_mul (
                .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(vI), .tag_i(tagI),
                .a(tagI.mag[k]), .b(gI),
                .cap((tagI.neg[k] != sneg) ? NEG_LIM : {1'b0, MAX_U}),
                .vld_o(vK), .tag_o(tagK), .p(pK[k])
            );
        end
        else
        begin : g_lane
            sfc_mulq u_mul (
                .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(1'b0), .tag_i('0),
                .a(tagI.mag[k]), .b(gI),
                .cap((tagI.neg[k] != sneg) ? NEG_LIM : {1'b0, MAX_U}),
                .vld_o(), .tag_o(), .p(pK[k])
            );
        end
    end

    sfc_mulq u_mul_de (
        .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(1'b0), .tag_i('0),
        .a({1'b0, tagI.de}), .b(gI), .cap({1'b0, MAX_U}),
        .vld_o(), .tag_o(), .p(pK[4])
    );

    // apply signs, add one to derivative
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            n = (tagK.neg[k] != sneg);
            out_next[k] = (n && (pK[k] != 48'd0)) ? (48'd0 - pK[k]) : pK[k];
        end
        de_sum  = {1'b0, pK[4][UW-1:0]} + {1'b0, Q_ONE};
        de_next = (de_sum > {1'b0, MAX_U}) ? MAX_U : de_sum[UW-1:0];
    end

    // hold result while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg  <= out_next;
            de_reg   <= de_next;
            kind_reg <= tagK.kind;
        end
    end

    assign out_valid = out_v_reg;
    assign out_x     = $signed(out_reg[0]);
    assign out_y     = $signed(out_reg[1]);
    assign out_z     = $signed(out_reg[2]);
    assign out_w     = $signed(out_reg[3]);
    assign de_out    = de_reg;
    assign fold_kind = kind_reg;

endmodule

### design/spherical_fold_cuboid_core.sv
// Channel  Handshake                  Payload
// in       in_valid / in_stall        coord_x..coord_w, iteration, de_in
// out      out_valid / out_stall      out_x..out_w, de_out, fold_kind
// cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item per cycle enters and leaves unless the output stalls; depth is set by the
// two 48-stage dividers (limit ratios, then max radius over chosen radius) and the
// four two-stage multipliers around them. Reset clears all valid bits and loads
// the register defaults. An output stall freezes the back pipeline; the queue and
// the front register keep accepting items until they fill.
module spherical_fold_cuboid_core #(
    parameter int QUEUE_DEPTH = sfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [47:0]  coord_x,
    input  logic signed [47:0]  coord_y,
    input  logic signed [47:0]  coord_z,
    input  logic signed [47:0]  coord_w,
    input  logic [15:0]         iteration,
    input  logic [46:0]         de_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [47:0]  out_x,
    output logic signed [47:0]  out_y,
    output logic signed [47:0]  out_z,
    output logic signed [47:0]  out_w,
    output logic [46:0]         de_out,
    output logic [1:0]          fold_kind
);
    import sfc_pkg::*;

    cfg_t   cfg_reg;
    side_t  push_data, head;
    logic   push, full, pop, empty;

    assign cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_r2      <= 47'd1073741824;
            cfg_reg.max_r2      <= 47'd4294967296;
            cfg_reg.scale       <= 48'd4294967296;
            cfg_reg.limit_x     <= 47'd8589934592;
            cfg_reg.limit_y     <= 47'd8589934592;
            cfg_reg.limit_z     <= 47'd8589934592;
            cfg_reg.mode_flags  <= 2'd0;
            cfg_reg.iter_window <= 32'd6553600;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN_R2:  cfg_reg.min_r2      <= cfg_data[46:0];
                REG_MAX_R2:  cfg_reg.max_r2      <= cfg_data[46:0];
                REG_SCALE:   cfg_reg.scale       <= cfg_data;
                REG_LIMIT_X: cfg_reg.limit_x     <= cfg_data[46:0];
                REG_LIMIT_Y: cfg_reg.limit_y     <= cfg_data[46:0];
                REG_LIMIT_Z: cfg_reg.limit_z     <= cfg_data[46:0];
                REG_MODE:    cfg_reg.mode_flags  <= cfg_data[1:0];
                REG_WINDOW:  cfg_reg.iter_window <= cfg_data[31:0];
                default:     cfg_reg.mode_flags  <= cfg_reg.mode_flags;
            endcase
        end
    end

    sfc_front u_front (
        .clk(clk), .rst_n(rst_n), .iter_window(cfg_reg.iter_window),
        .in_valid(in_valid), .in_stall(in_stall),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .coord_w(coord_w),
        .iteration(iteration), .de_in(de_in),
        .push(push), .push_data(push_data), .full(full)
    );

    sfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
        .pop(pop), .head(head), .empty(empty)
    );

    sfc_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .head(head), .empty(empty), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
        .de_out(de_out), .fold_kind(fold_kind)
    );

endmodule
